FILE: design/arsf_pkg.sv
package arsf_pkg;

	localparam int RESIDUAL_TAPS_DEF = 3;

	localparam int SAMPLE_W  = 16;
	localparam int LEVEL_W   = 40;
	localparam int TOTAL_W   = 42;
	localparam int RATIO_W   = 25;
	localparam int ACT_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	// serial divider: residual total magnitude over a 16-bit divisor
	localparam int DIV_DW = 42;
	localparam int DIV_SW = 16;
	localparam int DIV_CW = $clog2(DIV_DW + 1);

	// serial multiplier: 42-bit multiplicand, 25-bit multiplier
	localparam int MUL_AW = 42;
	localparam int MUL_BW = 25;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR   = 2'd3;

	localparam logic [15:0] RANGE_RST     = 16'd1000;
	localparam logic [13:0] THRESHOLD_RST = 14'd500;
	localparam logic [15:0] GAIN_RST      = 16'd13107;
	localparam logic [7:0]  DIVISOR_RST   = 8'd20;

	localparam logic [15:0] TEN_K = 16'd10000;

	typedef enum logic [1:0] {
		DIV_RANGE = 2'd0,
		DIV_TENK  = 2'd1,
		DIV_CORR  = 2'd2
	} div_sel_t;

	typedef enum logic [1:0] {
		MUL_GAIN   = 2'd0,
		MUL_SAMPLE = 2'd1,
		MUL_TENK   = 2'd2,
		MUL_RATIO  = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     div_start;
		div_sel_t div_sel;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     latch_act;
		logic     latch_ratio;
		logic     latch_lvl;
		logic     update_hist;
		logic     commit;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic mul_busy;
	} dp_stat_t;

endpackage

FILE: design/arsf_div.sv
module arsf_div #(
	parameter int DW = arsf_pkg::DIV_DW,
	parameter int SW = arsf_pkg::DIV_SW
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [$clog2(DW+1)-1:0]  count,
	input  logic [DW-1:0]            dividend,
	input  logic [SW-1:0]            divisor,
	output logic                     busy,
	output logic [DW-1:0]            quotient
);
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic [SW:0]   rem_sh;
	logic [SW:0]   rem_sub;
	logic [CW-1:0] shamt;

	assign shamt   = CW'(DW) - count;
	assign rem_sh  = {rem_q, quo_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= count;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend << shamt;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (rem_sh >= {1'b0, dvs_q}) begin
				rem_q <= rem_sub[SW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[SW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

FILE: design/arsf_mul.sv
module arsf_mul #(
	parameter int AW = arsf_pkg::MUL_AW,
	parameter int BW = arsf_pkg::MUL_BW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             busy,
	output logic [AW+BW-1:0] product
);
	localparam int CW = $clog2(BW + 1);

	logic [AW+BW-1:0] prod_q;
	logic [AW-1:0]    a_q;
	logic [CW-1:0]    cnt_q;
	logic [AW:0]      sum;

	assign sum = {1'b0, prod_q[AW+BW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(BW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift-add, multiplier bits consumed lsb first
	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= {{AW{1'b0}}, b};
			a_q    <= a;
		end else if (cnt_q != '0) begin
			prod_q <= {sum, prod_q[BW-1:1]};
		end
	end

	assign busy    = (cnt_q != '0);
	assign product = prod_q;

endmodule

FILE: design/arsf_ctrl.sv
module arsf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  arsf_pkg::dp_stat_t stat,
	output arsf_pkg::dp_cmd_t  cmd
);
	import arsf_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_DIV1 = 13'b0000000000010,
		S_MUL1 = 13'b0000000000100,
		S_MUL2 = 13'b0000000001000,
		S_DIV2 = 13'b0000000010000,
		S_POW  = 13'b0000000100000,
		S_MUL3 = 13'b0000001000000,
		S_RAT  = 13'b0000010000000,
		S_MUL4 = 13'b0000100000000,
		S_RES  = 13'b0001000000000,
		S_TOT  = 13'b0010000000000,
		S_DIV3 = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_take;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_take  = out_valid_q && !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.div_sel = DIV_RANGE;
		cmd.mul_sel = MUL_GAIN;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in   = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_RANGE;
					state_d       = S_DIV1;
				end
			end
			S_DIV1: begin
				if (!stat.div_busy) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_GAIN;
					state_d       = S_MUL1;
				end
			end
			S_MUL1: begin
				if (!stat.mul_busy) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_SAMPLE;
					state_d       = S_MUL2;
				end
			end
			S_MUL2: begin
				if (!stat.mul_busy) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_TENK;
					state_d       = S_DIV2;
				end
			end
			S_DIV2: begin
				if (!stat.div_busy) begin
					cmd.latch_act = 1'b1;
					state_d       = S_POW;
				end
			end
			S_POW: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_TENK;
				state_d       = S_MUL3;
			end
			S_MUL3: begin
				if (!stat.mul_busy) begin
					cmd.latch_ratio = 1'b1;
					state_d         = S_RAT;
				end
			end
			S_RAT: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_RATIO;
				state_d       = S_MUL4;
			end
			S_MUL4: begin
				if (!stat.mul_busy) begin
					cmd.latch_lvl = 1'b1;
					state_d       = S_RES;
				end
			end
			S_RES: begin
				cmd.update_hist = 1'b1;
				state_d         = S_TOT;
			end
			S_TOT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_CORR;
				state_d       = S_DIV3;
			end
			S_DIV3: begin
				cmd.div_sel = DIV_CORR;
				if (!stat.div_busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.div_sel = DIV_CORR;
				// wait for the output register to free up
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/arsf_dp.sv
module arsf_dp #(
	parameter int RESIDUAL_TAPS = arsf_pkg::RESIDUAL_TAPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  arsf_pkg::dp_cmd_t                   cmd,
	output arsf_pkg::dp_stat_t                  stat,
	input  logic [arsf_pkg::SAMPLE_W-1:0]       sample,
	input  logic                                cfg_we,
	input  logic [arsf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [arsf_pkg::CFG_W-1:0]          cfg_data,
	output logic [arsf_pkg::SAMPLE_W-1:0]       filtered,
	output logic [arsf_pkg::RATIO_W-1:0]        blend_ratio,
	output logic [arsf_pkg::ACT_W-1:0]          activity
);
	import arsf_pkg::*;

	localparam int SUMW = LEVEL_W + $clog2(RESIDUAL_TAPS) + 1;
	localparam logic signed [47:0] POW_BIAS_Q16 = 48'sd1064866805 <<< 16;
	localparam logic signed [46:0] POW_SLOPE    = 47'sd27749387;
	localparam logic [31:0] ACT_HI = 32'd655360;
	localparam logic [31:0] ACT_LO = 32'd327680;
	localparam logic [RATIO_W-1:0] RATIO_ONE = 25'd16777216;
	// ceil(2^44 / 10000), exact for dividends below 10000 * 2^16
	localparam logic [30:0] RECIP_TENK = 31'd1759218605;

	function automatic logic signed [LEVEL_W-1:0] sat_level(input logic signed [47:0] v);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = 48'sd549755813887;
		lo = -48'sd549755813888;
		if (v > hi) return LEVEL_W'(hi);
		else if (v < lo) return LEVEL_W'(lo);
		else return LEVEL_W'(v);
	endfunction

	function automatic logic signed [TOTAL_W-1:0] sat_total(input logic signed [47:0] v);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = 48'sd2199023255551;
		lo = -48'sd2199023255552;
		if (v > hi) return TOTAL_W'(hi);
		else if (v < lo) return TOTAL_W'(lo);
		else return TOTAL_W'(v);
	endfunction

	// configuration
	logic [15:0] range_q;
	logic [13:0] thresh_q;
	logic [15:0] gain_q;
	logic [7:0]  idiv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q  <= RANGE_RST;
			thresh_q <= THRESHOLD_RST;
			gain_q   <= GAIN_RST;
			idiv_q   <= DIVISOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE:     range_q  <= cfg_data;
				REG_THRESHOLD: thresh_q <= cfg_data[13:0];
				REG_GAIN:      gain_q   <= cfg_data;
				REG_DIVISOR:   idiv_q   <= cfg_data[7:0];
				default:       ;
			endcase
		end
	end

	// filter state
	logic signed [LEVEL_W-1:0] level_q;
	logic signed [LEVEL_W-1:0] hist_q [RESIDUAL_TAPS];
	logic signed [SUMW-1:0]    raw_q;
	logic signed [TOTAL_W-1:0] total_q;

	// per-item working registers
	logic [SAMPLE_W-1:0]       samp_q;
	logic [29:0]               thr_prod_q;
	logic [MUL_AW-1:0]         dmag_q;
	logic                      neg_q;
	logic [ACT_W-1:0]          act_q;
	logic signed [46:0]        pow_s1;
	logic [RATIO_W-1:0]        ratio_q;
	logic signed [42:0]        lvl_q;

	logic [SAMPLE_W-1:0]       filtered_q;
	logic [RATIO_W-1:0]        blend_q;
	logic [ACT_W-1:0]          act_out_q;

	// shared units
	logic [DIV_DW-1:0] div_dividend;
	logic [DIV_SW-1:0] div_divisor;
	logic [DIV_CW-1:0] div_count;
	logic [DIV_DW-1:0] quot;
	logic              gdiv_start;
	logic              gdiv_busy;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] prod;
	logic              mul_busy;

	logic [TOTAL_W-1:0] tot_mag;
	logic [15:0]        range_eff;
	logic [7:0]         idiv_eff;

	assign tot_mag   = total_q[TOTAL_W-1] ? TOTAL_W'(-total_q) : TOTAL_W'(total_q);
	assign range_eff = (range_q == '0) ? 16'd1 : range_q;
	assign idiv_eff  = (idiv_q == '0) ? 8'd1 : idiv_q;

	assign div_dividend = tot_mag;
	assign div_count    = DIV_CW'(TOTAL_W);

	always_comb begin
		unique case (cmd.div_sel)
			DIV_RANGE: div_divisor = range_eff;
			default:   div_divisor = {8'd0, idiv_eff};
		endcase
	end

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_GAIN: begin
				mul_a = quot[MUL_AW-1:0];
				mul_b = MUL_BW'(gain_q);
			end
			MUL_SAMPLE: begin
				mul_a = prod[MUL_AW+15:16];
				mul_b = MUL_BW'(samp_q);
			end
			MUL_TENK: begin
				mul_a = dmag_q;
				mul_b = MUL_BW'(TEN_K);
			end
			MUL_RATIO: begin
				mul_a = dmag_q;
				mul_b = ratio_q;
			end
			default: begin
				mul_a = dmag_q;
				mul_b = ratio_q;
			end
		endcase
	end

	assign gdiv_start = cmd.div_start && (cmd.div_sel != DIV_TENK);

	arsf_div #(
		.DW(DIV_DW),
		.SW(DIV_SW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (gdiv_start),
		.count   (div_count),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.busy    (gdiv_busy),
		.quotient(quot)
	);

	arsf_mul #(
		.AW(MUL_AW),
		.BW(MUL_BW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.product(prod)
	);

	// divide by ten thousand: long division in base 2^16, each digit by reciprocal:
	// a digit estimate is registered, then the remainder is updated from it
	logic [63:0] tk_x_q;
	logic [13:0] tk_rem_q;
	logic [29:0] tk_v_q;
	logic [15:0] tk_dig_q;
	logic [63:0] tk_quo_q;
	logic [3:0]  tk_cnt_q;
	logic        tk_start;
	logic        tk_busy;
	logic [29:0] tk_v;
	logic [59:0] tk_est;
	logic [29:0] tk_back;

	assign tk_start = cmd.div_start && (cmd.div_sel == DIV_TENK);
	assign tk_busy  = (tk_cnt_q != '0);
	assign tk_v     = {tk_rem_q, tk_x_q[63:48]};
	assign tk_est   = 60'(tk_v) * 60'(RECIP_TENK);
	assign tk_back  = 30'(tk_dig_q) * 30'(TEN_K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tk_cnt_q <= '0;
		end else if (tk_start) begin
			tk_cnt_q <= 4'd8;
		end else if (tk_busy) begin
			tk_cnt_q <= tk_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tk_start) begin
			tk_x_q   <= {6'd0, prod[57:0]};
			tk_rem_q <= '0;
			tk_quo_q <= '0;
		end else if (tk_busy) begin
			if (!tk_cnt_q[0]) begin
				tk_v_q   <= tk_v;
				tk_dig_q <= tk_est[59:44];
				tk_x_q   <= {tk_x_q[47:0], 16'd0};
			end else begin
				tk_rem_q <= 14'(tk_v_q - tk_back);
				tk_quo_q <= {tk_quo_q[47:0], tk_dig_q};
			end
		end
	end

	assign stat.div_busy = gdiv_busy || tk_busy;
	assign stat.mul_busy = mul_busy;

	// distance from level at load
	logic signed [41:0] diff_in;
	assign diff_in = signed'(42'({10'd0, sample, 16'd0})) - 42'(level_q);

	// exponent and float-bit power of ten
	logic signed [20:0] b_exp;
	always_comb begin
		if (act_q >= ACT_HI) begin
			b_exp = '0;
		end else if (act_q <= ACT_LO) begin
			b_exp = -21'sd327680;
		end else begin
			b_exp = signed'({1'b0, act_q[19:0]}) - 21'sd655360;
		end
	end

	logic signed [47:0]  pow_sum;
	logic [30:0]         t_bits;
	logic [7:0]          t_exp;
	logic [23:0]         t_mant;
	logic [7:0]          shift;
	logic [RATIO_W-1:0]  ratio_pow;
	logic                jump;

	assign pow_sum = 48'(pow_s1) + POW_BIAS_Q16;
	assign t_bits  = pow_sum[46:16];
	assign t_exp   = t_bits[30:23];
	assign t_mant  = {1'b1, t_bits[22:0]};
	assign shift   = 8'd126 - t_exp;

	always_comb begin
		if (t_exp >= 8'd126) begin
			ratio_pow = RATIO_W'(t_mant);
		end else if (shift >= 8'd32) begin
			ratio_pow = '0;
		end else begin
			ratio_pow = RATIO_W'(t_mant >> shift[4:0]);
		end
	end

	assign jump = (prod >= MUL_PW'({thr_prod_q, 16'd0}));

	// blend step and residual
	logic [42:0]              step;
	logic signed [42:0]       lvl_new;
	logic signed [44:0]       res_full;
	logic signed [LEVEL_W-1:0] res_sat;
	logic signed [SUMW-1:0]   raw_new;
	logic signed [42:0]       corr;
	logic signed [47:0]       level_sum;
	logic signed [LEVEL_W-1:0] level_new;

	assign step    = prod[MUL_PW-1:24];
	assign lvl_new = neg_q ? (43'(level_q) - signed'(step)) : (43'(level_q) + signed'(step));
	assign res_full = signed'(45'({13'd0, samp_q, 16'd0})) - 45'(lvl_q);
	assign res_sat  = sat_level(48'(res_full));
	assign raw_new  = raw_q - SUMW'(hist_q[0]) + SUMW'(res_sat);

	// division rounds toward zero: apply sign to the magnitude quotient
	assign corr      = total_q[TOTAL_W-1] ? -signed'({1'b0, quot[41:0]})
	                                      : signed'({1'b0, quot[41:0]});
	assign level_sum = 48'(lvl_q) + 48'(corr);
	assign level_new = sat_level(level_sum);

	always_ff @(posedge clk) begin
		pow_s1 <= 47'(b_exp) * POW_SLOPE;
		if (cmd.load_in) begin
			samp_q     <= sample;
			thr_prod_q <= 30'(thresh_q) * 30'(sample);
			neg_q      <= diff_in[41];
			dmag_q     <= diff_in[41] ? MUL_AW'(-diff_in) : MUL_AW'(diff_in);
		end
		if (cmd.latch_act) begin
			act_q <= (tk_quo_q[63:ACT_W] != '0) ? '1 : tk_quo_q[ACT_W-1:0];
		end
		if (cmd.latch_ratio) begin
			ratio_q <= jump ? RATIO_ONE : ratio_pow;
		end
		if (cmd.latch_lvl) begin
			lvl_q <= lvl_new;
		end
		if (cmd.commit) begin
			blend_q   <= ratio_q;
			act_out_q <= act_q;
			if (level_new[LEVEL_W-1]) begin
				filtered_q <= '0;
			end else if (level_new[LEVEL_W-2:32] != '0) begin
				filtered_q <= '1;
			end else begin
				filtered_q <= level_new[31:16];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			raw_q   <= '0;
			total_q <= '0;
			for (int i = 0; i < RESIDUAL_TAPS; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (cmd.update_hist) begin
				for (int i = 0; i < RESIDUAL_TAPS - 1; i++) begin
					hist_q[i] <= hist_q[i+1];
				end
				hist_q[RESIDUAL_TAPS-1] <= res_sat;
				raw_q   <= raw_new;
				total_q <= sat_total(48'(raw_new));
			end
			if (cmd.commit) begin
				level_q <= level_new;
			end
		end
	end

	assign filtered    = filtered_q;
	assign blend_ratio = blend_q;
	assign activity    = act_out_q;

endmodule

FILE: design/adaptive_range_smoothing_filter_unit.sv
// adaptive range smoothing filter
//
// input channel: in_valid / in_stall with one 16-bit distance sample per beat.
// output channel: out_valid / out_stall with filtered level, blend ratio (Q1.24)
// and activity (Q16.16) per beat; every input beat gives exactly one output beat.
// configuration: cfg_we with cfg_index and cfg_data writes one register per edge;
// write only while no sample is in flight.
// one sample is processed at a time. the time per sample is spent mostly in the
// one-bit-a-cycle divider (two passes of 42 steps), the shift-add multiplier
// (four passes of 25 steps) and the divide by ten thousand.
// a finished result sits in the output register; the next sample is taken while
// it waits. if the receiver stalls, the following result holds inside the block
// and no new sample is taken until the output register frees up.
// reset clears level, residual history and totals and loads the register defaults
// (range 1000, threshold 500, gain 0.2, divisor 20).
module adaptive_range_smoothing_filter_unit #(
	parameter int RESIDUAL_TAPS = arsf_pkg::RESIDUAL_TAPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [arsf_pkg::SAMPLE_W-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [arsf_pkg::SAMPLE_W-1:0]   filtered,
	output logic [arsf_pkg::RATIO_W-1:0]    blend_ratio,
	output logic [arsf_pkg::ACT_W-1:0]      activity,
	input  logic                            cfg_we,
	input  logic [arsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [arsf_pkg::CFG_W-1:0]      cfg_data
);
	import arsf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	arsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	arsf_dp #(
		.RESIDUAL_TAPS(RESIDUAL_TAPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.sample     (sample),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.filtered   (filtered),
		.blend_ratio(blend_ratio),
		.activity   (activity)
	);

endmodule
